// ===== design/bdeq_pkg.sv =====
// Shared types and codes for the bounded double-ended queue.
// No dependencies; imported by every other design file.
package bdeq_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned FuncW   = 3;
  localparam int unsigned StatusW = 2;

  typedef enum logic [FuncW-1:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_TRAVERSE   = 3'd4
  } bdeq_func_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2,
    STATUS_EMPTY     = 2'd3
  } bdeq_status_e;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    OP_HOLD       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_ROTATE     = 3'd4
  } bdeq_op_e;

  typedef struct packed {
    logic [FuncW-1:0]        func;
    logic signed [WordW-1:0] value;
  } bdeq_in_t;

  typedef struct packed {
    logic signed [WordW-1:0] word;
    logic [StatusW-1:0]      status;
    logic                    last;
  } bdeq_out_t;

  typedef struct packed {
    bdeq_op_e                op;
    logic signed [WordW-1:0] value;
  } bdeq_chain_ctl_t;

endpackage

// ===== design/bdeq_cell.sv =====
// One storage cell of the deque chain: a word and an occupancy bit.
// Depends on bdeq_pkg.
module bdeq_cell import bdeq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bdeq_chain_ctl_t         ctl_i,
  input  logic signed [WordW-1:0] left_word_i,
  input  logic                    left_valid_i,
  input  logic signed [WordW-1:0] right_word_i,
  input  logic                    right_valid_i,
  input  logic signed [WordW-1:0] head_word_i,
  output logic signed [WordW-1:0] word_o,
  output logic                    valid_o
);

  logic signed [WordW-1:0] word_q, word_d;
  logic                    valid_q, valid_d;

  always_comb begin
    word_d  = word_q;
    valid_d = valid_q;
    case (ctl_i.op)
      OP_PUSH_FRONT: begin
        word_d  = left_word_i;
        valid_d = left_valid_i;
      end
      OP_PUSH_BACK: begin
        // first empty cell takes the new word
        if (!valid_q && left_valid_i) begin
          word_d  = ctl_i.value;
          valid_d = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        word_d  = right_word_i;
        valid_d = right_valid_i;
      end
      OP_ROTATE: begin
        // tail cell wraps the head word around
        if (valid_q) begin
          word_d = right_valid_i ? right_word_i : head_word_i;
        end
      end
      default: begin
        word_d  = word_q;
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o  = word_q;
  assign valid_o = valid_q;

endmodule

// ===== design/bdeq_ctrl.sv =====
// Sequencer of the deque: command register, fill count, step counter
// and result register. Drives the cell chain. Depends on bdeq_pkg.
module bdeq_ctrl import bdeq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  bdeq_in_t                in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output bdeq_out_t               out_data_o,
  input  logic signed [WordW-1:0] head_word_i,
  output bdeq_chain_ctl_t         chain_ctl_o
);

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned StepW = $clog2(DEPTH);

  logic             cmd_valid_q, cmd_valid_d;
  bdeq_in_t         cmd_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  bdeq_out_t        out_q, res;

  logic             slot_free, full, empty, at_end, emit, done, accept;
  logic [StepW-1:0] last_idx;
  bdeq_op_e         op;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign full      = (count_q == CntW'(DEPTH));
  assign empty     = (count_q == '0);
  assign last_idx  = StepW'(count_q - CntW'(1));
  assign at_end    = (step_q == last_idx);

  always_comb begin
    emit       = 1'b0;
    done       = 1'b0;
    op         = OP_HOLD;
    count_d    = count_q;
    step_d     = step_q;
    res.word   = '0;
    res.status = STATUS_OK;
    res.last   = 1'b1;
    if (cmd_valid_q) begin
      case (bdeq_func_e'(cmd_q.func))
        FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
          if (slot_free) begin
            emit = 1'b1;
            done = 1'b1;
            if (full) begin
              res.status = STATUS_OVERFLOW;
            end else begin
              op      = (bdeq_func_e'(cmd_q.func) == FUNC_PUSH_FRONT) ?
                        OP_PUSH_FRONT : OP_PUSH_BACK;
              count_d = count_q + CntW'(1);
            end
          end
        end
        FUNC_POP_FRONT: begin
          if (slot_free) begin
            emit = 1'b1;
            done = 1'b1;
            if (empty) begin
              res.status = STATUS_UNDERFLOW;
            end else begin
              res.word = head_word_i;
              op       = OP_POP_FRONT;
              count_d  = count_q - CntW'(1);
            end
          end
        end
        FUNC_POP_BACK: begin
          // rotate the tail word up to the head, then pop it
          if (empty || at_end) begin
            if (slot_free) begin
              emit = 1'b1;
              done = 1'b1;
              if (empty) begin
                res.status = STATUS_UNDERFLOW;
              end else begin
                res.word = head_word_i;
                op       = OP_POP_FRONT;
                count_d  = count_q - CntW'(1);
                step_d   = '0;
              end
            end
          end else begin
            op     = OP_ROTATE;
            step_d = step_q + StepW'(1);
          end
        end
        FUNC_TRAVERSE: begin
          if (slot_free) begin
            emit = 1'b1;
            if (empty) begin
              res.status = STATUS_EMPTY;
              done       = 1'b1;
            end else begin
              res.word = head_word_i;
              res.last = at_end;
              op       = OP_ROTATE;
              if (at_end) begin
                done   = 1'b1;
                step_d = '0;
              end else begin
                step_d = step_q + StepW'(1);
              end
            end
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  assign in_stall_o  = cmd_valid_q && !done;
  assign accept      = in_valid_i && !in_stall_o;
  assign cmd_valid_d = accept ? 1'b1 : (done ? 1'b0 : cmd_valid_q);
  assign out_valid_d = slot_free ? emit : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      count_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
      count_q     <= count_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_data_i;
    end
    if (emit) begin
      out_q <= res;
    end
  end

  assign chain_ctl_o.op    = op;
  assign chain_ctl_o.value = cmd_q.value;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count above depth");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> slot_free)
    else $error("result overwrites a waiting result");

  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != '0) |-> cmd_valid_q)
    else $error("step counter active with no item");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_q && !empty) |-> (step_q <= last_idx))
    else $error("step counter past the tail");

endmodule

// ===== design/bounded_double_ended_queue.sv =====
// Top level of the bounded double-ended queue: a chain of cells plus its
// sequencer. Depends on bdeq_pkg, bdeq_cell and bdeq_ctrl.
//
// Holds up to DEPTH signed 32-bit words in a row of cells; cell 0 is always
// the front of the deque and the occupied cells form a contiguous run from
// it. Push front, push back and pop front need no rotation pass, so such
// items can be accepted back to back while the output does not stall. Pop
// back rotates the chain by one position per cycle until the tail word sits
// in cell 0, then pops it; pushes and front pops shift the whole run by one
// cell. A traverse rotates the chain once per stored word and emits each
// word as it passes cell 0, so after the traverse the order is back to where
// it started. A push into a full deque returns overflow and is dropped; a
// pop from an empty one returns underflow. func codes five to seven are
// swallowed without a result. One item is held in a command register while
// it works, and results go out through a separate output register, so a new
// item is taken while an earlier result still waits. No clearing pass is
// needed after reset: the cells' occupancy bits are cleared at once.
module bounded_double_ended_queue import bdeq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  bdeq_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output bdeq_out_t out_data_o
);

  bdeq_chain_ctl_t         chain_ctl;
  logic signed [WordW-1:0] word_w  [DEPTH];
  logic                    valid_w [DEPTH];

  bdeq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .head_word_i (word_w[0]),
    .chain_ctl_o (chain_ctl)
  );

  // Cell 0 sees the pushed word as its left neighbor; the last cell sees
  // an empty right neighbor.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [WordW-1:0] left_word, right_word;
    logic                    left_valid, right_valid;

    if (k == 0) begin : g_head
      assign left_word  = chain_ctl.value;
      assign left_valid = 1'b1;
    end else begin : g_mid
      assign left_word  = word_w[k-1];
      assign left_valid = valid_w[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign right_word  = '0;
      assign right_valid = 1'b0;
    end else begin : g_body
      assign right_word  = word_w[k+1];
      assign right_valid = valid_w[k+1];
    end

    bdeq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (chain_ctl),
      .left_word_i   (left_word),
      .left_valid_i  (left_valid),
      .right_word_i  (right_word),
      .right_valid_i (right_valid),
      .head_word_i   (word_w[0]),
      .word_o        (word_w[k]),
      .valid_o       (valid_w[k])
    );
  end

endmodule

// ===== verif/bounded_double_ended_queue_tb.sv =====
// Self-checking testbench for bounded_double_ended_queue: directed corner items, then
// random push/pop/traverse phases, checked item by item by a scoreboard class.
// Depends on bdeq_pkg and the RTL under design/.
module bounded_double_ended_queue_tb import bdeq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 250;
  // A pop back rotates the whole chain, so the wait after the last result
  // before calling the run done is sized from DEPTH.
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  // Operation mix of one random phase.
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } op_mix_e;

  // Receiver back-pressure styles.
  typedef enum int {
    RX_FLOW,
    RX_LIGHT,
    RX_PERIODIC,
    RX_HEAVY
  } rx_style_e;

  // Keeps its own ring, front index and fill count, and turns every accepted
  // item into the results the deque owes for it.
  class deque_scoreboard;
    logic signed [WordW-1:0] ring [DEPTH];
    int unsigned             head;
    int unsigned             fill;
    bdeq_out_t               due_results [$];
    int unsigned             faults;

    function new();
      head   = 0;
      fill   = 0;
      faults = 0;
    endfunction

    function void add_due(logic signed [WordW-1:0] word, bdeq_status_e status, logic last);
      bdeq_out_t r;
      r.word   = word;
      r.status = status;
      r.last   = last;
      due_results.push_back(r);
    endfunction

    function void apply_op(bdeq_in_t item);
      int unsigned pos;
      int unsigned idx;
      case (item.func)
        FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
          if (fill >= DEPTH) begin
            add_due('0, STATUS_OVERFLOW, 1'b1);
          end else begin
            if (item.func == FUNC_PUSH_FRONT) begin
              head = (head + DEPTH - 1) % DEPTH;
              pos  = head;
            end else begin
              pos = (head + fill) % DEPTH;
            end
            ring[pos] = item.value;
            fill++;
            add_due('0, STATUS_OK, 1'b1);
          end
        end
        FUNC_POP_FRONT: begin
          if (fill == 0) begin
            add_due('0, STATUS_UNDERFLOW, 1'b1);
          end else begin
            add_due(ring[head], STATUS_OK, 1'b1);
            head = (head + 1) % DEPTH;
            fill--;
          end
        end
        FUNC_POP_BACK: begin
          if (fill == 0) begin
            add_due('0, STATUS_UNDERFLOW, 1'b1);
          end else begin
            pos = (head + fill - 1) % DEPTH;
            add_due(ring[pos], STATUS_OK, 1'b1);
            fill--;
          end
        end
        FUNC_TRAVERSE: begin
          if (fill == 0) begin
            add_due('0, STATUS_EMPTY, 1'b1);
          end else begin
            for (idx = 0; idx < fill; idx++) begin
              pos = (head + idx) % DEPTH;
              add_due(ring[pos], STATUS_OK, (idx + 1 == fill));
            end
          end
        end
        default: ; // spare codes are swallowed
      endcase
    endfunction

    function void check_result(bdeq_out_t got);
      bdeq_out_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: word %0d status %0d last %0b",
               got.word, got.status, got.last);
        faults++;
        return;
      end
      want = due_results.pop_front();
      if (got.word !== want.word) begin
        $error("word: expected %0d, got %0d", want.word, got.word);
        faults++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        faults++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        faults++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  bdeq_in_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  bdeq_out_t out_data;

  deque_scoreboard scoreboard;
  int unsigned     burst_left = 0;
  int unsigned     cycle_count = 0;

  bounded_double_ended_queue #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Monitor. Reads happen right after the edge, before any NBA of this step
  // lands, so they see exactly what the DUT saw at that edge. The input side
  // is noted before the output side is checked.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_valid && in_stall === 1'b0) begin
        scoreboard.apply_op(in_data);
      end
      if (out_valid === 1'b1 && !out_stall) begin
        scoreboard.check_result(out_data);
      end
    end
  end

  // Receiver back-pressure: switches style as its run counter expires, so both
  // long free-flowing stretches and stalls at every phase of a traverse occur.
  rx_style_e   rx_style = RX_FLOW;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_style <= rx_style_e'($urandom_range(0, 3));
      rx_left  <= $urandom_range(20, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_style)
      RX_FLOW:     out_stall <= 1'b0;
      RX_LIGHT:    out_stall <= ($urandom_range(0, 2) == 0);
      RX_PERIODIC: out_stall <= ((rx_tick % 7) < 3);
      default:     out_stall <= ($urandom_range(0, 2) != 0);
    endcase
  end

  // Watchdog on total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("bounded_double_ended_queue test failed");
    $finish;
  end

  // Send one item. Bursts of random length are separated by random gaps;
  // a gap of zero keeps valid high across the boundary, giving stretches
  // without idling. Valid is only lowered at the start of a gap, so it never
  // gets two NBAs in one step.
  task automatic send(logic [FuncW-1:0] func, logic signed [WordW-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_data.func  <= func;
    in_data.value <= value;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // Empty-deque cases, spare codes, the value extremes, both ends, traverse
  // with contents, and draining back to empty.
  task automatic run_directed();
    send(FUNC_TRAVERSE, $urandom);
    send(FUNC_POP_FRONT, $urandom);
    send(FUNC_POP_BACK, $urandom);
    send(3'(FUNC_TRAVERSE) + 3'd1, $urandom);
    send(3'(FUNC_TRAVERSE) + 3'd2, $urandom);
    send(3'(FUNC_TRAVERSE) + 3'd3, $urandom);
    send(FUNC_PUSH_FRONT, 32'sh8000_0000);
    send(FUNC_PUSH_BACK, 32'sh7fff_ffff);
    send(FUNC_PUSH_FRONT, -32'sd1);
    send(FUNC_PUSH_BACK, 32'sd0);
    send(FUNC_PUSH_FRONT, 32'sh5555_5555);
    send(FUNC_PUSH_BACK, 32'shaaaa_aaaa);
    send(FUNC_TRAVERSE, $urandom);
    send(FUNC_POP_BACK, $urandom);
    send(FUNC_POP_FRONT, $urandom);
    send(FUNC_TRAVERSE, $urandom);
    send(FUNC_POP_BACK, $urandom);
    send(FUNC_POP_FRONT, $urandom);
    send(FUNC_POP_FRONT, $urandom);
    send(FUNC_POP_BACK, $urandom);
    send(FUNC_POP_BACK, $urandom);
    send(FUNC_TRAVERSE, $urandom);
  endtask

  function automatic logic [FuncW-1:0] pick_func(op_mix_e mix);
    int unsigned roll;
    int unsigned push_limit;
    logic        back_end;
    roll     = $urandom_range(0, 99);
    back_end = 1'($urandom_range(0, 1));
    case (mix)
      MIX_FILL:  push_limit = 92;
      MIX_DRAIN: push_limit = 20;
      default:   push_limit = 56;
    endcase
    if (roll < 4) begin
      return 3'(FUNC_TRAVERSE) + 3'($urandom_range(1, 3));
    end else if (roll < 12) begin
      return FUNC_TRAVERSE;
    end else if (roll < push_limit) begin
      return back_end ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
    end
    return back_end ? FUNC_POP_BACK : FUNC_POP_FRONT;
  endfunction

  function automatic logic signed [WordW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Random phases. The first one fills the deque so overflow and full
  // traverses show up early; later phases pick fill, drain or even mixes.
  task automatic run_random();
    int unsigned      counted;
    int unsigned      phase_left;
    op_mix_e          mix;
    logic [FuncW-1:0] func;
    counted    = 0;
    phase_left = 30;
    mix        = MIX_FILL;
    while (counted < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        mix        = op_mix_e'($urandom_range(0, 2));
        phase_left = $urandom_range(10, 40);
      end
      phase_left--;
      func = pick_func(mix);
      send(func, pick_value());
      if (func <= FUNC_TRAVERSE) begin
        counted++;
      end
    end
  endtask

  initial begin
    scoreboard = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random();
    in_valid <= 1'b0;

    // Everything owed must arrive; the watchdog catches a hang here.
    while (scoreboard.due_results.size() != 0) @(posedge clk);
    // Extra cycles let any stray result show up and be flagged.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (scoreboard.faults == 0 && scoreboard.due_results.size() == 0) begin
      $display("bounded_double_ended_queue test passed");
    end else begin
      $display("bounded_double_ended_queue test failed");
    end
    $finish;
  end

endmodule
